### hdl/box_distance_iou_top_assert.svh
// Assertion macros shared by the queue and back-end blocks of the distance-IoU evaluator.
// Arguments must not contain commas.
`ifndef BOX_DISTANCE_IOU_TOP_ASSERT_SVH
`define BOX_DISTANCE_IOU_TOP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define BDI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BDI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bdi_pkg.sv
package bdi_pkg;

  // Input word layout: eight 16-bit coordinate fields.
  localparam int FIELD_BITS = 16;
  localparam int IN_FIELDS = 8;
  localparam int IN_TDATA_BITS = FIELD_BITS * IN_FIELDS;

  // Result format: signed Q1.15 with room for exactly plus one.
  localparam int FRAC_BITS = 15;
  localparam int RES_BITS = FRAC_BITS + 2;
  localparam int OUT_TDATA_BITS = 24;

  // Quotients carry two integer bits and FRAC_BITS fraction bits.
  localparam int DIV_STEPS = FRAC_BITS + 2;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = 2;

  typedef logic signed [RES_BITS-1:0] res_t;

  localparam res_t RES_MIN = -(RES_BITS'(1) <<< FRAC_BITS);
  localparam res_t RES_MAX = (RES_BITS'(1) <<< FRAC_BITS);

endpackage

### hdl/bdi_queue.sv
`include "box_distance_iou_top_assert.svh"

module bdi_queue #(
  parameter int WIDTH = 140
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  import bdi_pkg::*;

  localparam int CW = QUEUE_AW + 1;

  logic [WIDTH-1:0] mem [0:QUEUE_DEPTH-1];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic push;
  logic pop;

  assign in_ready = (count != CW'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_data = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  // Storage for queued words.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `BDI_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(QUEUE_DEPTH), "queue overfilled")
  `BDI_ASSERT_NEXT(a_count_rise, clk, rst, push && !pop, count == $past(count) + CW'(1), "count did not rise")
  `BDI_ASSERT_NEXT(a_count_hold, clk, rst, push && pop, $stable(count), "count moved on push and pop")

endmodule

### hdl/bdi_front.sv
module bdi_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bdi_pkg::IN_TDATA_BITS-1:0]   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2*COORD_BITS-1:0]             inter,
  output logic [2*COORD_BITS:0]               uni,
  output logic [2*COORD_BITS+4:0]             num2,
  output logic [2*COORD_BITS+5:0]             den2
);
  import bdi_pkg::*;

  localparam int C = COORD_BITS;
  localparam logic [3:0] HALF = 4'd8;

  // Whole pixels from a Q.4 length, ties to even.
  function automatic logic [C-3:0] round_px(input logic [C:0] v);
    logic [C-4:0] ip;
    logic up;
    ip = v[C:4];
    up = (v[3:0] > HALF) || ((v[3:0] == HALF) && ip[0]);
    return (C-2)'(ip) + (C-2)'(up);
  endfunction

  logic en;
  logic v1, v2, v3, v4;

  logic [C-1:0] al, at, aw, ah, bl, bt, bw, bh;
  logic [C:0] ar, ab, br, bb;
  logic [C-1:0] ix0, iy0, ex_lo, ey_lo;
  logic [C:0] ix1, iy1, ex_hi, ey_hi;
  logic [C-1:0] ixw_c, iyw_c;
  logic [C:0] ew_c, eh_c;
  logic a_empty, b_empty;
  logic [C+1:0] sxa, sxb, sya, syb, adx_c, ady_c;

  logic [2*C-1:0] s1_area_a, s1_area_b;
  logic [C-1:0] s1_ixw, s1_iyw;
  logic [C:0] s1_ew, s1_eh;
  logic [C+1:0] s1_adx, s1_ady;

  logic [2*C-1:0] s2_area_a, s2_area_b, s2_inter;
  logic [C-3:0] s2_ew, s2_eh;
  logic [2*C+3:0] s2_sqx, s2_sqy;

  logic [2*C-1:0] s3_inter;
  logic [2*C:0] s3_uni;
  logic [2*C-5:0] s3_ew2, s3_eh2;
  logic [2*C+4:0] s3_num2;

  logic [2*C-4:0] c2;

  assign en = !v4 || out_ready;
  assign in_ready = en;
  assign out_valid = v4;

  // Field extraction; only the low COORD_BITS bits take part.
  assign al = C'(in_data[0*FIELD_BITS +: FIELD_BITS]);
  assign at = C'(in_data[1*FIELD_BITS +: FIELD_BITS]);
  assign aw = C'(in_data[2*FIELD_BITS +: FIELD_BITS]);
  assign ah = C'(in_data[3*FIELD_BITS +: FIELD_BITS]);
  assign bl = C'(in_data[4*FIELD_BITS +: FIELD_BITS]);
  assign bt = C'(in_data[5*FIELD_BITS +: FIELD_BITS]);
  assign bw = C'(in_data[6*FIELD_BITS +: FIELD_BITS]);
  assign bh = C'(in_data[7*FIELD_BITS +: FIELD_BITS]);

  // Edges, overlap extents, enclosing box and doubled centre offsets.
  always_comb begin
    ar = (C+1)'(al) + (C+1)'(aw);
    ab = (C+1)'(at) + (C+1)'(ah);
    br = (C+1)'(bl) + (C+1)'(bw);
    bb = (C+1)'(bt) + (C+1)'(bh);
    ix0 = (al > bl) ? al : bl;
    iy0 = (at > bt) ? at : bt;
    ix1 = (ar < br) ? ar : br;
    iy1 = (ab < bb) ? ab : bb;
    ixw_c = (ix1 > (C+1)'(ix0)) ? C'(ix1 - (C+1)'(ix0)) : '0;
    iyw_c = (iy1 > (C+1)'(iy0)) ? C'(iy1 - (C+1)'(iy0)) : '0;
    ex_lo = (al < bl) ? al : bl;
    ey_lo = (at < bt) ? at : bt;
    ex_hi = (ar > br) ? ar : br;
    ey_hi = (ab > bb) ? ab : bb;
    a_empty = (aw == '0) || (ah == '0);
    b_empty = (bw == '0) || (bh == '0);
    if (a_empty) begin
      ew_c = (C+1)'(bw);
      eh_c = (C+1)'(bh);
    end else if (b_empty) begin
      ew_c = (C+1)'(aw);
      eh_c = (C+1)'(ah);
    end else begin
      ew_c = ex_hi - (C+1)'(ex_lo);
      eh_c = ey_hi - (C+1)'(ey_lo);
    end
    sxa = (C+2)'(al) + (C+2)'(ar);
    sxb = (C+2)'(bl) + (C+2)'(br);
    sya = (C+2)'(at) + (C+2)'(ab);
    syb = (C+2)'(bt) + (C+2)'(bb);
    adx_c = (sxa > sxb) ? sxa - sxb : sxb - sxa;
    ady_c = (sya > syb) ? sya - syb : syb - sya;
  end

  assign c2 = (2*C-3)'(s3_ew2) + (2*C-3)'(s3_eh2);

  // Valid chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Four geometry stages.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_area_a <= (2*C)'(aw) * (2*C)'(ah);
      s1_area_b <= (2*C)'(bw) * (2*C)'(bh);
      s1_ixw <= ixw_c;
      s1_iyw <= iyw_c;
      s1_ew <= ew_c;
      s1_eh <= eh_c;
      s1_adx <= adx_c;
      s1_ady <= ady_c;

      s2_area_a <= s1_area_a;
      s2_area_b <= s1_area_b;
      s2_inter <= (2*C)'(s1_ixw) * (2*C)'(s1_iyw);
      s2_ew <= round_px(s1_ew);
      s2_eh <= round_px(s1_eh);
      s2_sqx <= (2*C+4)'(s1_adx) * (2*C+4)'(s1_adx);
      s2_sqy <= (2*C+4)'(s1_ady) * (2*C+4)'(s1_ady);

      s3_inter <= s2_inter;
      s3_uni <= (2*C+1)'(s2_area_a) + (2*C+1)'(s2_area_b) - (2*C+1)'(s2_inter);
      s3_ew2 <= (2*C-4)'(s2_ew) * (2*C-4)'(s2_ew);
      s3_eh2 <= (2*C-4)'(s2_eh) * (2*C-4)'(s2_eh);
      s3_num2 <= (2*C+5)'(s2_sqx) + (2*C+5)'(s2_sqy);

      // Empty union and empty diagonal become harmless divisions.
      // The squared diagonal never reaches its top bit, so it drops here.
      inter <= s3_inter;
      uni <= (s3_uni == '0) ? (2*C+1)'(1) : s3_uni;
      num2 <= (c2 == '0) ? '0 : s3_num2;
      den2 <= (c2 == '0) ? (2*C+6)'(1) : (2*C+6)'({c2, 10'b0});
    end
  end

endmodule

### hdl/bdi_back.sv
`include "box_distance_iou_top_assert.svh"

module bdi_back #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2*COORD_BITS-1:0] inter,
  input  logic [2*COORD_BITS:0]   uni,
  input  logic [2*COORD_BITS+4:0] num2,
  input  logic [2*COORD_BITS+5:0] den2,
  output logic                    out_valid,
  input  logic                    out_ready,
  output bdi_pkg::res_t           out_value
);
  import bdi_pkg::*;

  localparam int C = COORD_BITS;
  localparam int DW = 2*C + 6;
  localparam int RW = DW + 2;
  localparam int HW = (RW + 1) / 2;
  localparam int PW = 4 * HW;
  localparam int QW = DIV_STEPS;
  localparam int S = DIV_STEPS;
  localparam logic [QW-1:0] Q_ONE = QW'(1) << FRAC_BITS;
  localparam logic signed [QW+1:0] LO_X = (QW+2)'(RES_MIN);
  localparam logic signed [QW+1:0] HI_X = (QW+2)'(RES_MAX);

  logic en;
  logic sat0;

  // Divider pipelines: stage 0 is the load, stages 1..S one quotient bit each.
  logic [S:0] vld;
  logic [S:0] sat;
  logic [RW-1:0] r1 [0:S];
  logic [RW-1:0] r2 [0:S];
  logic [DW-1:0] d1 [0:S];
  logic [DW-1:0] d2 [0:S];
  logic [QW-1:0] q1 [0:S];
  logic [QW-1:0] q2 [0:S];

  // Cross-multiply stages for the sign of the leftover fractions.
  logic [3:0] mv;
  logic [HW-1:0] a_lo, a_hi, da_lo, da_hi, b_lo, b_hi, db_lo, db_hi;
  logic [2*HW-1:0] pa00, pa01, pa10, pa11, pb00, pb01, pb10, pb11;
  logic [QW-1:0] m1_q1, m1_q2;
  logic m1_sat;
  logic [2*HW-1:0] m2_pa00, m2_pa11, m2_pb00, m2_pb11;
  logic [2*HW:0] m2_mida, m2_midb;
  logic signed [QW:0] m2_base;
  logic m2_sat;
  logic [PW-1:0] m3_pa, m3_pb;
  logic signed [QW:0] m3_base;
  logic m3_sat;
  logic out_sat;

  logic gt, lt, pos;
  logic signed [QW+1:0] base_x, adj;

  assign en = !mv[3] || out_ready;
  assign in_ready = en;
  assign out_valid = mv[3];

  // A distance ratio of four or more drives the result below minus one.
  assign sat0 = RW'(num2) >= {den2, 2'b00};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      mv <= '0;
    end else if (en) begin
      vld <= {vld[S-1:0], in_valid};
      mv <= {mv[2:0], vld[S]};
    end
  end

  // Load stage.
  always_ff @(posedge clk) begin
    if (en) begin
      r1[0] <= RW'(inter);
      d1[0] <= DW'(uni);
      r2[0] <= sat0 ? '0 : RW'(num2);
      d2[0] <= den2;
      q1[0] <= '0;
      q2[0] <= '0;
      sat[0] <= sat0;
    end
  end

  // Restoring division steps against four times the divisor.
  for (genvar k = 1; k <= S; k++) begin : g_step
    logic [RW:0] t1, t2, dd1, dd2;
    logic ge1, ge2;
    assign t1 = {r1[k-1], 1'b0};
    assign t2 = {r2[k-1], 1'b0};
    assign dd1 = (RW+1)'({d1[k-1], 2'b00});
    assign dd2 = (RW+1)'({d2[k-1], 2'b00});
    assign ge1 = t1 >= dd1;
    assign ge2 = t2 >= dd2;
    always_ff @(posedge clk) begin
      if (en) begin
        r1[k] <= ge1 ? RW'(t1 - dd1) : RW'(t1);
        r2[k] <= ge2 ? RW'(t2 - dd2) : RW'(t2);
        q1[k] <= {q1[k-1][QW-2:0], ge1};
        q2[k] <= {q2[k-1][QW-2:0], ge2};
        d1[k] <= d1[k-1];
        d2[k] <= d2[k-1];
        sat[k] <= sat[k-1];
      end
    end
  end

  // Split the remainder products into half-width pieces.
  always_comb begin
    a_lo = r1[S][HW-1:0];
    a_hi = HW'(r1[S] >> HW);
    da_lo = HW'(d2[S]);
    da_hi = HW'(RW'(d2[S]) >> HW);
    b_lo = r2[S][HW-1:0];
    b_hi = HW'(r2[S] >> HW);
    db_lo = HW'(d1[S]);
    db_hi = HW'(RW'(d1[S]) >> HW);
  end

  // Final sign decision, truncation toward zero and clamping.
  always_comb begin
    gt = m3_pa > m3_pb;
    lt = m3_pa < m3_pb;
    base_x = {m3_base[QW], m3_base};
    pos = (base_x > (QW+2)'(0)) || ((base_x == (QW+2)'(0)) && !lt);
    if (pos) begin
      adj = lt ? base_x - (QW+2)'(1) : base_x;
    end else begin
      adj = gt ? base_x + (QW+2)'(1) : base_x;
    end
    if (m3_sat || (adj < LO_X)) begin
      adj = LO_X;
    end else if (adj > HI_X) begin
      adj = HI_X;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa00 <= (2*HW)'(a_lo) * (2*HW)'(da_lo);
      pa01 <= (2*HW)'(a_lo) * (2*HW)'(da_hi);
      pa10 <= (2*HW)'(a_hi) * (2*HW)'(da_lo);
      pa11 <= (2*HW)'(a_hi) * (2*HW)'(da_hi);
      pb00 <= (2*HW)'(b_lo) * (2*HW)'(db_lo);
      pb01 <= (2*HW)'(b_lo) * (2*HW)'(db_hi);
      pb10 <= (2*HW)'(b_hi) * (2*HW)'(db_lo);
      pb11 <= (2*HW)'(b_hi) * (2*HW)'(db_hi);
      m1_q1 <= q1[S];
      m1_q2 <= q2[S];
      m1_sat <= sat[S];

      m2_pa00 <= pa00;
      m2_pa11 <= pa11;
      m2_pb00 <= pb00;
      m2_pb11 <= pb11;
      m2_mida <= (2*HW+1)'(pa01) + (2*HW+1)'(pa10);
      m2_midb <= (2*HW+1)'(pb01) + (2*HW+1)'(pb10);
      m2_base <= $signed({1'b0, m1_q1}) - $signed({1'b0, m1_q2});
      m2_sat <= m1_sat;

      m3_pa <= (PW'(m2_pa11) << (2*HW)) + (PW'(m2_mida) << HW) + PW'(m2_pa00);
      m3_pb <= (PW'(m2_pb11) << (2*HW)) + (PW'(m2_midb) << HW) + PW'(m2_pb00);
      m3_base <= m2_base;
      m3_sat <= m2_sat;

      out_value <= adj[RES_BITS-1:0];
      out_sat <= m3_sat;
    end
  end

  `BDI_ASSERT_NOW(a_iou_bound, clk, rst, vld[S], q1[S] <= Q_ONE, "IoU quotient above one")
  `BDI_ASSERT_NOW(a_sat_out, clk, rst, mv[3] && out_sat, out_value == RES_MIN, "saturated word not at minimum")
  `BDI_ASSERT_NEXT(a_stall_hold, clk, rst, !en, $stable(vld) && $stable(mv), "pipeline moved while stalled")

endmodule

### hdl/box_distance_iou_top.sv
// Distance-IoU of two axis-aligned boxes given as left, top, width and height in
// unsigned Q12.4 pixels; one signed Q1.15 result word per input word. The block
// takes one box pair every clock cycle unless the output side holds. A word passes
// through the geometry in the front, the four-word queue, and in the back one load
// stage, seventeen one-bit restoring division steps (one per quotient bit) and the
// remainder cross-multiplication and final rounding. The front and back stall
// independently; the queue absorbs up to four words while the output side holds.
// Results below minus one saturate at -32768.
module box_distance_iou_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // a_left, a_top, a_width, a_height, b_left, b_top, b_width, b_height (16 bits each)
  input  logic [bdi_pkg::IN_TDATA_BITS-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // diou_value (17 bits, signed), zero fill above
  output logic [bdi_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);
  import bdi_pkg::*;

  localparam int C = COORD_BITS;
  localparam int QWID = 8*C + 12;

  logic f_valid, f_ready;
  logic [2*C-1:0] f_inter;
  logic [2*C:0] f_uni;
  logic [2*C+4:0] f_num2;
  logic [2*C+5:0] f_den2;

  logic q_valid, q_ready;
  logic [QWID-1:0] q_data;
  res_t value;

  bdi_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_data(s_tdata),
    .out_valid(f_valid),
    .out_ready(f_ready),
    .inter(f_inter),
    .uni(f_uni),
    .num2(f_num2),
    .den2(f_den2)
  );

  bdi_queue #(.WIDTH(QWID)) u_queue (
    .clk(clk),
    .rst(rst),
    .in_valid(f_valid),
    .in_ready(f_ready),
    .in_data({f_den2, f_num2, f_uni, f_inter}),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_data(q_data)
  );

  bdi_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk(clk),
    .rst(rst),
    .in_valid(q_valid),
    .in_ready(q_ready),
    .inter(q_data[2*C-1:0]),
    .uni(q_data[4*C:2*C]),
    .num2(q_data[6*C+5:4*C+1]),
    .den2(q_data[8*C+11:6*C+6]),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_value(value)
  );

  assign m_tdata = {{(OUT_TDATA_BITS-RES_BITS){1'b0}}, value};

endmodule
